// ----- design/y2r_pkg.sv -----
// y2r_pkg: shared types and constants for the yuv 4:2:2 to rgb888 pixel converter
// bt.601 coefficients scaled by 1000, channel sum width and the divide-by-1000 reciprocal
// no dependencies
`default_nettype none

package y2r_pkg;

  // signed width of one channel sum before the divide (covers about +-1M)
  localparam int unsigned SUM_W = 21;

  localparam logic signed [SUM_W-1:0] COEF_Y  = 21'sd1164;
  localparam logic signed [SUM_W-1:0] COEF_RV = 21'sd1596;
  localparam logic signed [SUM_W-1:0] COEF_GV = 21'sd813;
  localparam logic signed [SUM_W-1:0] COEF_GU = 21'sd391;
  localparam logic signed [SUM_W-1:0] COEF_BU = 21'sd2018;
  localparam logic signed [SUM_W-1:0] ROUND_OFS = 21'sd500;
  localparam logic signed [SUM_W-1:0] LUMA_OFS  = 21'sd16;
  localparam logic signed [SUM_W-1:0] CHROMA_OFS = 21'sd128;

  // sums below this give zero, at or above SAT_HIGH give full scale
  localparam logic signed [SUM_W-1:0] SAT_LOW  = 21'sd1000;
  localparam logic signed [SUM_W-1:0] SAT_HIGH = 21'sd256000;

  // floor(n / 1000) = (n * ceil(2^28 / 1000)) >> 28, exact for n < 2^18
  localparam int unsigned DIV_NUM_W   = 18;
  localparam int unsigned DIV_RECIP_W = 19;
  localparam int unsigned DIV_SHIFT   = 28;
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 19'd268436;

  localparam int unsigned LINE_W_BITS = 13;
  localparam logic [LINE_W_BITS-1:0] LINE_W_RESET = 13'd640;

  typedef struct packed {
    logic signed [SUM_W-1:0] blue;
    logic signed [SUM_W-1:0] green;
    logic signed [SUM_W-1:0] red;
  } y2r_sums_t;

endpackage

`default_nettype wire

// ----- design/y2r_sat_div.sv -----
// y2r_sat_div: divides one channel sum by 1000 with truncation and saturates to 0..255
// combinational; uses y2r_pkg for widths and the reciprocal constant
`default_nettype none

module y2r_sat_div
  import y2r_pkg::*;
(
  input  wire logic signed [SUM_W-1:0] sum_i,
  output logic [7:0]                   chan_o
);

  logic [DIV_NUM_W-1:0]             num;
  logic [DIV_NUM_W+DIV_RECIP_W-1:0] prod;

  always_comb begin
    num  = sum_i[DIV_NUM_W-1:0];
    prod = (DIV_NUM_W+DIV_RECIP_W)'(num) * (DIV_NUM_W+DIV_RECIP_W)'(DIV_RECIP);
    priority if (sum_i < SAT_LOW) begin
      // negative quotients and those truncated to zero both land here
      chan_o = 8'd0;
    end else if (sum_i >= SAT_HIGH) begin
      chan_o = 8'd255;
    end else begin
      chan_o = prod[DIV_SHIFT+7:DIV_SHIFT];
    end
  end

endmodule

`default_nettype wire

// ----- design/yuv422_pixel_to_rgb_core.sv -----
// yuv422_pixel_to_rgb_core: converts one yuv 4:2:2 pixel with its chroma neighborhood to rgb888
// depends on y2r_pkg and y2r_sat_div
//
// usage:
//   s_axis carries one pixel request: column, luma and the interleaved chroma samples at
//   columns x-1, x, x+1 and x+2. m_axis returns red, green and blue for that pixel.
//   cfg_* writes line_width (pixels per line), used to spot the last odd column; write it
//   only while no request is in flight. cfg_ready_o is always high.
// timing:
//   three register stages: input register, channel sum register, result register.
//   a request moves from the input register to the channel sum register, then to the result
//   register, whose output drives m_axis. one request per cycle sustained; the pipeline
//   advances whenever the result register is empty or being taken.
// stall:
//   when m_axis_tready is low the result holds, and the stages behind it keep filling
//   their empty slots; s_axis_tready drops only once all three stages hold data.
// reset:
//   rst_ni clears all stage valid flags and sets line_width to 640.
`default_nettype none

module yuv422_pixel_to_rgb_core
  import y2r_pkg::*;
#(
  parameter int unsigned COLUMN_BITS = 12,
  localparam int unsigned InBits = COLUMN_BITS + 40,
  localparam int unsigned InDataW = ((InBits + 7) / 8) * 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,

  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [LINE_W_BITS-1:0] cfg_data_i,

  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // column, luma, chroma_left, chroma_here, chroma_right, chroma_right_two (lsb first)
  input  wire logic [InDataW-1:0] s_axis_tdata,

  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // red, green, blue (lsb first)
  output logic [23:0]             m_axis_tdata
);

  localparam int unsigned CmpW = ((COLUMN_BITS > LINE_W_BITS) ? COLUMN_BITS : LINE_W_BITS) + 1;

  logic [LINE_W_BITS-1:0] line_w_q;

  // input stage
  logic                   a_vld_q;
  logic [COLUMN_BITS-1:0] col_q;
  logic [7:0]             luma_q, cl_q, ch_q, cr_q, cr2_q;

  // sum stage
  logic      b_vld_q;
  y2r_sums_t sums_d, sums_q;

  // result stage
  logic       o_vld_q;
  logic [7:0] red_d, grn_d, blu_d;
  logic [23:0] rgb_q;

  logic en_a, en_b, en_o;

  assign en_o = ~o_vld_q | m_axis_tready;
  assign en_b = ~b_vld_q | en_o;
  assign en_a = ~a_vld_q | en_b;

  assign s_axis_tready = en_a;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tdata  = rgb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_w_q <= LINE_W_RESET;
      a_vld_q  <= 1'b0;
      b_vld_q  <= 1'b0;
      o_vld_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        line_w_q <= cfg_data_i;
      end
      if (en_a) begin
        a_vld_q <= s_axis_tvalid;
      end
      if (en_b) begin
        b_vld_q <= a_vld_q;
      end
      if (en_o) begin
        o_vld_q <= b_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && s_axis_tvalid) begin
      col_q  <= s_axis_tdata[COLUMN_BITS-1:0];
      luma_q <= s_axis_tdata[COLUMN_BITS+7:COLUMN_BITS];
      cl_q   <= s_axis_tdata[COLUMN_BITS+15:COLUMN_BITS+8];
      ch_q   <= s_axis_tdata[COLUMN_BITS+23:COLUMN_BITS+16];
      cr_q   <= s_axis_tdata[COLUMN_BITS+31:COLUMN_BITS+24];
      cr2_q  <= s_axis_tdata[COLUMN_BITS+39:COLUMN_BITS+32];
    end
    if (en_b && a_vld_q) begin
      sums_q <= sums_d;
    end
    if (en_o && b_vld_q) begin
      rgb_q <= {blu_d, grn_d, red_d};
    end
  end

  // chroma pick and channel sums
  logic                    last_col;
  logic [8:0]              u_avg, v_avg;
  logic [7:0]              u_sel, v_sel;
  logic signed [SUM_W-1:0] y_s, u_s, v_s, yt;

  always_comb begin
    last_col = (CmpW'(col_q) + CmpW'(1)) == CmpW'(line_w_q);
    u_avg    = 9'(cl_q) + 9'(cr_q);
    v_avg    = 9'(ch_q) + 9'(cr2_q);
    priority if (!col_q[0]) begin
      u_sel = ch_q;
      v_sel = cr_q;
    end else if (last_col) begin
      u_sel = cl_q;
      v_sel = ch_q;
    end else begin
      u_sel = u_avg[8:1];
      v_sel = v_avg[8:1];
    end

    y_s = $signed(SUM_W'(luma_q)) - LUMA_OFS;
    u_s = $signed(SUM_W'(u_sel)) - CHROMA_OFS;
    v_s = $signed(SUM_W'(v_sel)) - CHROMA_OFS;
    yt  = y_s * COEF_Y;

    sums_d.red   = yt + COEF_RV * v_s + ROUND_OFS;
    sums_d.green = yt - COEF_GV * v_s - COEF_GU * u_s + ROUND_OFS;
    sums_d.blue  = yt + COEF_BU * u_s + ROUND_OFS;
  end

  y2r_sat_div u_div_red (
    .sum_i  (sums_q.red),
    .chan_o (red_d)
  );

  y2r_sat_div u_div_grn (
    .sum_i  (sums_q.green),
    .chan_o (grn_d)
  );

  y2r_sat_div u_div_blu (
    .sum_i  (sums_q.blue),
    .chan_o (blu_d)
  );

endmodule

`default_nettype wire

// ----- verif/tb_yuv422_pixel_to_rgb_core.sv -----
// tb_yuv422_pixel_to_rgb_core: self-checking bench for the yuv 4:2:2 to rgb888 pixel converter
// random and directed pixel requests with a bt.601 predictor and an in-order result scoreboard
// depends on y2r_pkg and yuv422_pixel_to_rgb_core
`timescale 1ns / 100ps

module tb_yuv422_pixel_to_rgb_core
  import y2r_pkg::*;
();

  localparam int unsigned ColW = 12;
  localparam int unsigned ReqW = 56;
  localparam int unsigned LongHold = 60;
  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned RandPerPhase = 100;

  typedef struct packed {
    logic [7:0]      chroma_right_two;
    logic [7:0]      chroma_right;
    logic [7:0]      chroma_here;
    logic [7:0]      chroma_left;
    logic [7:0]      luma;
    logic [ColW-1:0] column;
  } pixel_req_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  class rgb_scoreboard;
    logic [LINE_W_BITS-1:0] line_width;
    rgb_t expected_q[$];
    int   mismatches;
    int   requests;
    int   results;

    function new();
      line_width = LINE_W_RESET;
      mismatches = 0;
      requests = 0;
      results = 0;
    endfunction

    // divide by 1000 toward zero, then clip to 0..255
    static function logic [7:0] clip_channel(int sum);
      int q;
      q = sum / 1000;
      if (q < 0) return 8'd0;
      if (q > 255) return 8'd255;
      return q[7:0];
    endfunction

    function rgb_t convert(pixel_req_t r);
      int   u;
      int   v;
      int   yt;
      rgb_t c;
      if (!r.column[0]) begin
        u = r.chroma_here;
        v = r.chroma_right;
      end else if (int'(r.column) == int'(line_width) - 1) begin
        u = r.chroma_left;
        v = r.chroma_here;
      end else begin
        u = (int'(r.chroma_left) + int'(r.chroma_right)) / 2;
        v = (int'(r.chroma_here) + int'(r.chroma_right_two)) / 2;
      end
      yt = 1164 * (int'(r.luma) - 16);
      u = u - 128;
      v = v - 128;
      c.red = clip_channel(yt + 1596 * v + 500);
      c.green = clip_channel(yt - 813 * v - 391 * u + 500);
      c.blue = clip_channel(yt + 2018 * u + 500);
      return c;
    endfunction

    function void note_request(pixel_req_t r);
      expected_q.push_back(convert(r));
      requests++;
    endfunction

    function void check_result(rgb_t got);
      rgb_t want;
      results++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result r=%0d g=%0d b=%0d", $time,
                   got.red, got.green, got.blue);
        return;
      end
      want = expected_q.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   $time, want.red, want.green, want.blue, got.red, got.green, got.blue);
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [LINE_W_BITS-1:0] cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [ReqW-1:0]        s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [23:0]            m_axis_tdata;

  rgb_scoreboard sb;
  bit            calm;
  int            hold_requests;
  int            hold_done;
  int            width_writes;

  yuv422_pixel_to_rgb_core #(
    .COLUMN_BITS(ColW)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // requests, results and register writes, all seen at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_request(pixel_req_t'(s_axis_tdata[$bits(pixel_req_t)-1:0]));
      if (m_axis_tvalid && m_axis_tready) sb.check_result(rgb_t'(m_axis_tdata));
      if (cfg_valid_i && cfg_ready_o) begin
        sb.line_width = cfg_data_i;
        width_writes++;
      end
    end
  end

  // result side back-pressure
  initial begin
    m_axis_tready = 1'b0;
    hold_done = 0;
    #1;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (hold_done != hold_requests) begin
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_done++;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o) || !rst_ni)
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no progress for %0d cycles", QuietLimit);
    $display("Test completed with failures");
    $finish;
  end

  // valid stays high across back-to-back requests; gaps lower it
  task automatic send_pixel(input pixel_req_t r);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ReqW'(r);
    do @(posedge clk_i); while (!s_axis_tready);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_line_width(input logic [LINE_W_BITS-1:0] w);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pixel_req_t random_pixel(input logic [LINE_W_BITS-1:0] w);
    pixel_req_t r;
    logic [LINE_W_BITS-1:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2: c = w - 1'b1;
      3:       c = w - 2'd2;
      4:       c = w;
      default: c = LINE_W_BITS'($urandom);
    endcase
    r.column = c[ColW-1:0];
    r.luma = pick_sample();
    r.chroma_left = pick_sample();
    r.chroma_here = pick_sample();
    r.chroma_right = pick_sample();
    r.chroma_right_two = pick_sample();
    return r;
  endfunction

  function automatic pixel_req_t make_pixel(input int col, input int y, input int cl,
                                            input int ch, input int cr, input int cr2);
    pixel_req_t r;
    r.column = col[ColW-1:0];
    r.luma = y[7:0];
    r.chroma_left = cl[7:0];
    r.chroma_here = ch[7:0];
    r.chroma_right = cr[7:0];
    r.chroma_right_two = cr2[7:0];
    return r;
  endfunction

  initial begin
    logic [LINE_W_BITS-1:0] widths[6];
    logic [LINE_W_BITS-1:0] w;
    sb = new();
    calm = 1'b0;
    hold_requests = 0;
    width_writes = 0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // line width still at its reset value here
    send_pixel(make_pixel(0, 0, 0, 0, 0, 0));
    send_pixel(make_pixel(0, 255, 255, 255, 255, 255));
    send_pixel(make_pixel(2, 16, 9, 128, 128, 9));
    send_pixel(make_pixel(4, 235, 0, 128, 128, 0));
    send_pixel(make_pixel(6, 128, 77, 0, 255, 77));
    send_pixel(make_pixel(8, 128, 77, 255, 0, 77));
    send_pixel(make_pixel(1, 128, 255, 10, 254, 11));
    send_pixel(make_pixel(3, 200, 0, 255, 1, 254));
    send_pixel(make_pixel(5, 255, 255, 255, 255, 255));
    send_pixel(make_pixel(7, 0, 0, 0, 0, 0));
    send_pixel(make_pixel(639, 100, 30, 220, 5, 250));
    send_pixel(make_pixel(639, 255, 255, 0, 0, 0));
    send_pixel(make_pixel(638, 90, 1, 2, 3, 4));
    send_pixel(make_pixel(640, 60, 200, 40, 180, 20));
    send_pixel(make_pixel(641, 60, 200, 40, 180, 20));
    send_pixel(make_pixel(4094, 180, 66, 99, 140, 33));
    send_pixel(make_pixel(4095, 180, 66, 99, 140, 33));
    send_pixel(make_pixel(2730, 170, 85, 170, 85, 170));
    send_pixel(make_pixel(1365, 85, 170, 85, 170, 85));

    widths[0] = 13'd2;
    widths[1] = 13'd4096;
    widths[2] = 13'd0;
    widths[3] = 13'd641;
    widths[4] = 13'd8191;
    widths[5] = 13'($urandom_range(2, 4096));
    foreach (widths[p]) begin
      w = widths[p];
      write_line_width(w);
      send_pixel(make_pixel(int'(w) - 1, 150, 40, 210, 90, 160));
      send_pixel(make_pixel(int'(w) - 2, 150, 40, 210, 90, 160));
      if (p == 1) hold_requests++;
      if (p == 5) calm = 1'b1;
      repeat (RandPerPhase) send_pixel(random_pixel(w));
    end

    drain_results();
    $display("covered %0d pixel requests and %0d results over %0d line-width writes",
             sb.requests, sb.results, width_writes);
    $display("including even, averaged odd, last-column, zero and out-of-range widths");
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.expected_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/y2r_pkg.sv
design/y2r_sat_div.sv
design/yuv422_pixel_to_rgb_core.sv
verif/tb_yuv422_pixel_to_rgb_core.sv
